### rtl/core/rrdf_pkg.sv
// ============================================================================
// Recent request duplicate filter: shared types and constants
// Sizes, register codes, entry layout and the controller/datapath
// command and status groups.
// ============================================================================
package rrdf_pkg;

   localparam int DEPTH      = 128;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int LIMIT_W    = 8;
   localparam int CMP_W      = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
   localparam int REQ_W      = 48;
   localparam int ID_W       = 32;
   localparam int TICK_W     = 32;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPIRY_TICKS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_LIMIT  = 1'b1;

   localparam logic [TICK_W-1:0]  EXPIRY_RESET = 32'd10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 8'd100;

   typedef struct packed {
      logic [REQ_W-1:0]  requester;
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] tick;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_SEARCH,
      ST_SHIFT,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      SCAN_EXPIRE,
      SCAN_SEARCH,
      SCAN_SHIFT
   } scan_mode_type;

   typedef struct packed {
      logic          load;
      logic          init;
      logic          init_after_hit;
      logic          run;
      scan_mode_type mode;
      logic          commit_expiry;
      logic          save_hit;
      logic          update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic expire_stop;
      logic match;
      logic rsp_busy;
   } dp_status_type;

endpackage

### rtl/core/rrdf_if.sv
// ============================================================================
// Recent request duplicate filter: channel interfaces
// Request, response and register write channels with valid/ready.
// ============================================================================
interface rrdf_req_if import rrdf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  requester_addr;
   logic [ID_W-1:0]   request_id;
   logic [TICK_W-1:0] time_now;

   modport source(output valid, requester_addr, request_id, time_now, input ready);
   modport sink(input valid, requester_addr, request_id, time_now, output ready);
endinterface

interface rrdf_rsp_if import rrdf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               is_duplicate;
   logic [COUNT_W-1:0] entry_count;

   modport source(output valid, is_duplicate, entry_count, input ready);
   modport sink(input valid, is_duplicate, entry_count, output ready);
endinterface

interface rrdf_csr_if import rrdf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

### rtl/core/rrdf_ctrl.sv
// ============================================================================
// Recent request duplicate filter: controller
// Sequences expiry scan, search, compaction and update for one request.
// ============================================================================
module rrdf_ctrl import rrdf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mode  = SCAN_EXPIRE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.init = 1'b1;
               state_in = ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            cmd.run  = 1'b1;
            cmd.mode = SCAN_EXPIRE;
            if (sts.expire_stop) begin
               cmd.commit_expiry = 1'b1;
               cmd.init          = 1'b1;
               state_in          = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.run  = 1'b1;
            cmd.mode = SCAN_SEARCH;
            if (sts.match) begin
               cmd.save_hit       = 1'b1;
               cmd.init_after_hit = 1'b1;
               state_in           = ST_SHIFT;
            end else if (sts.scan_end) begin
               state_in = ST_UPDATE;
            end
         end
         ST_SHIFT: begin
            cmd.run  = 1'b1;
            cmd.mode = SCAN_SHIFT;
            if (sts.scan_end) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Hold the finished result until the output register is free.
            if (!sts.rsp_busy) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/rrdf_datapath.sv
// ============================================================================
// Recent request duplicate filter: datapath
// Entry memory as a circular list, scan pipeline, registers and result.
// ============================================================================
module rrdf_datapath import rrdf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         sts,
   input  logic [REQ_W-1:0]      req_requester_addr,
   input  logic [ID_W-1:0]       req_request_id,
   input  logic [TICK_W-1:0]     req_time_now,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_is_duplicate,
   output logic [COUNT_W-1:0]    rsp_entry_count
);

   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   entry_type entry_mem [DEPTH];

   logic [TICK_W-1:0]  expiry_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [ADDR_W-1:0]  head_ff,    head_in;
   logic [CNT_W-1:0]   count_ff,   count_in;
   entry_type          req_ff;
   logic [CNT_W-1:0]   iss_off_ff, iss_off_in;
   logic               rd_vld_ff,  rd_vld_in;
   logic [CNT_W-1:0]   rd_off_ff;
   entry_type          rd_data_ff;
   logic [CNT_W-1:0]   exp_n_ff,   exp_n_in;
   logic               hit_ff,     hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_dup_ff;
   logic [COUNT_W-1:0] rsp_cnt_ff;

   logic               issue;
   logic [ADDR_W-1:0]  rd_addr;
   logic [TICK_W-1:0]  age;
   logic               expired;
   logic               match;
   logic [CMP_W-1:0]   lim_eff;
   logic               miss_full;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_data;

   assign issue   = cmd.run && (iss_off_ff < count_ff);
   assign rd_addr = wrap_addr(head_ff, iss_off_ff);
   // Ages wrap modulo the tick width, so a stamp in the future looks very old.
   assign age     = req_ff.tick - rd_data_ff.tick;
   assign expired = age > expiry_ff;
   assign match   = rd_vld_ff && (rd_data_ff.id == req_ff.id)
                    && (rd_data_ff.requester == req_ff.requester);

   assign lim_eff   = (CMP_W'(limit_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(limit_ff);
   assign miss_full = (CMP_W'(count_ff) + CMP_W'(1)) > lim_eff;

   always_comb begin
      sts.scan_end    = !rd_vld_ff && (iss_off_ff == count_ff);
      sts.expire_stop = sts.scan_end || (rd_vld_ff && !expired);
      sts.match       = match;
      sts.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   // Scan pipeline: one read issued per cycle, its data checked in the next cycle.
   always_comb begin
      iss_off_in = iss_off_ff;
      rd_vld_in  = issue;
      exp_n_in   = exp_n_ff;
      hit_in     = hit_ff;
      if (cmd.init) begin
         iss_off_in = '0;
         rd_vld_in  = 1'b0;
         exp_n_in   = '0;
      end else if (cmd.init_after_hit) begin
         iss_off_in = rd_off_ff + CNT_W'(1);
         rd_vld_in  = 1'b0;
      end else if (issue) begin
         iss_off_in = iss_off_ff + CNT_W'(1);
      end
      if (cmd.run && (cmd.mode == SCAN_EXPIRE) && rd_vld_ff && expired && !cmd.init) begin
         exp_n_in = rd_off_ff + CNT_W'(1);
      end
      if (cmd.load) begin
         hit_in = 1'b0;
      end else if (cmd.save_hit) begin
         hit_in = 1'b1;
      end
   end

   // List bookkeeping and the single memory write port.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = wrap_addr(head_ff, count_ff);
      wr_data  = req_ff;
      if (cmd.commit_expiry) begin
         head_in  = wrap_addr(head_ff, exp_n_ff);
         count_in = count_ff - exp_n_ff;
      end else if (cmd.run && (cmd.mode == SCAN_SHIFT) && rd_vld_ff) begin
         // Close the gap left by the matched entry.
         wr_en   = 1'b1;
         wr_addr = wrap_addr(head_ff, rd_off_ff - CNT_W'(1));
         wr_data = rd_data_ff;
      end else if (cmd.update) begin
         if (hit_ff) begin
            wr_en   = 1'b1;
            wr_addr = wrap_addr(head_ff, count_ff - CNT_W'(1));
         end else if (miss_full) begin
            // The head is evicted and the new entry is written after the tail.
            if (count_ff != '0) begin
               wr_en   = 1'b1;
               head_in = wrap_addr(head_ff, CNT_W'(1));
            end
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff    <= EXPIRY_RESET;
         limit_ff     <= LIMIT_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         iss_off_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         exp_n_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_EXPIRY_TICKS: expiry_ff <= csr_wdata[TICK_W-1:0];
               CSR_CACHE_LIMIT:  limit_ff  <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         head_ff      <= head_in;
         count_ff     <= count_in;
         iss_off_ff   <= iss_off_in;
         rd_vld_ff    <= rd_vld_in;
         exp_n_ff     <= exp_n_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_off_ff <= iss_off_ff;
      if (cmd.load) begin
         req_ff.requester <= req_requester_addr;
         req_ff.id        <= req_request_id;
         req_ff.tick      <= req_time_now;
      end
      if (cmd.update) begin
         rsp_dup_ff <= hit_ff;
         rsp_cnt_ff <= COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_duplicate = rsp_dup_ff;
   assign rsp_entry_count  = rsp_cnt_ff;

endmodule

### rtl/core/recent_request_duplicate_filter_core.sv
// ============================================================================
// Recent request duplicate filter core
// Time-expiring cache of recent requests that flags repeated requests.
// ============================================================================
// Each request beat is handled one at a time out of an entry memory with one
// read port and one write port, organized as a circular, age-ordered list.
// The memory read port sets the pace: each request reads every expired head
// entry, every entry searched and, after a hit, every entry moved up to close
// the gap; its result waits while the previous one is still stalled on the
// response channel. A new request is taken while the previous result still
// waits on the response channel. Register writes take effect at once and need
// no clearing pass; the list starts empty after reset.
module recent_request_duplicate_filter_core import rrdf_pkg::*; (
   input logic         clock,
   input logic         reset,
   rrdf_req_if.sink    req_bus,
   rrdf_rsp_if.source  rsp_bus,
   rrdf_csr_if.sink    csr_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;
   logic          req_ready;

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   rrdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rrdf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_requester_addr (req_bus.requester_addr),
      .req_request_id     (req_bus.request_id),
      .req_time_now       (req_bus.time_now),
      .csr_valid          (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_wdata          (csr_bus.wdata),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_is_duplicate   (rsp_bus.is_duplicate),
      .rsp_entry_count    (rsp_bus.entry_count)
   );

endmodule

### rtl/core/rrdf_checker.sv
// ============================================================================
// Recent request duplicate filter: port checker
// Checks result ordering and result values seen at the top level ports.
// ============================================================================
module rrdf_checker import rrdf_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_is_duplicate,
   input logic [COUNT_W-1:0] rsp_entry_count
);

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat   = req_valid && req_ready;
   assign rsp_beat   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + 2'(req_beat) - 2'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_duplicate)
                                  && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   // Every response beat belongs to an earlier request beat.
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> pending_ff != 2'd0)
      else $error("response without a request");

   // At most one finished and one working request are in flight.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many requests in flight");

   // A duplicate was found in the list, so the list cannot be empty.
   a_dup_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_duplicate |-> rsp_entry_count != '0)
      else $error("duplicate reported with an empty list");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_entry_count) <= DEPTH)
      else $error("entry count above capacity");

endmodule

bind recent_request_duplicate_filter_core rrdf_checker u_rrdf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_is_duplicate (rsp_bus.is_duplicate),
   .rsp_entry_count  (rsp_bus.entry_count)
);

### test/duplicate_filter_checker.sv
// ============================================================================
// Duplicate filter checker
// Watches the request, response and register channels of the filter core,
// keeps its own copy of the recent request list and compares every response
// beat, in order, with the verdict that the list predicts.
// ============================================================================
module duplicate_filter_checker import rrdf_pkg::*; (
   input  logic clock,
   input  logic reset,
   rrdf_req_if  req_bus,
   rrdf_rsp_if  rsp_bus,
   rrdf_csr_if  csr_bus,
   output int   fail_count,
   output int   outstanding,
   output int   responses_seen,
   output int   repeats_seen,
   output int   peak_entries
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               is_duplicate;
      logic [COUNT_W-1:0] entry_count;
   } verdict_type;

   entry_type          recent_q[$];
   verdict_type        verdict_q[$];
   logic [TICK_W-1:0]  expiry_ticks = EXPIRY_RESET;
   logic [LIMIT_W-1:0] cache_limit  = LIMIT_RESET;
   int                 fails   = 0;
   int                 seen    = 0;
   int                 repeats = 0;
   int                 peak    = 0;

   // Ages the list, looks the request up and updates the list the way the
   // core does, returning the verdict the core must give for this beat.
   task automatic lookup_request(input logic [REQ_W-1:0] who, input logic [ID_W-1:0] id,
                                 input logic [TICK_W-1:0] now, output verdict_type verdict);
      int                limit_eff;
      int                pos;
      bit                hit;
      logic [TICK_W-1:0] age;
      entry_type         fresh;
      limit_eff = (cache_limit > DEPTH) ? DEPTH : cache_limit;
      fresh.requester = who;
      fresh.id = id;
      fresh.tick = now;
      // Ages wrap, so an entry stamped later than now looks very old.
      while (recent_q.size() > 0) begin
         age = now - recent_q[0].tick;
         if (age <= expiry_ticks) break;
         recent_q.delete(0);
      end
      hit = 1'b0;
      for (pos = 0; pos < recent_q.size(); pos++) begin
         if (recent_q[pos].id == id && recent_q[pos].requester == who) begin
            hit = 1'b1;
            break;
         end
      end
      if (hit) begin
         recent_q.delete(pos);
         recent_q = {recent_q, fresh};
      end else if (recent_q.size() + 1 > limit_eff) begin
         // A zero limit on an empty list keeps it empty.
         if (recent_q.size() > 0) begin
            recent_q.delete(0);
            recent_q = {recent_q, fresh};
         end
      end else begin
         recent_q = {recent_q, fresh};
      end
      verdict.is_duplicate = hit;
      verdict.entry_count = COUNT_W'(recent_q.size());
   endtask

   always @(posedge clock) begin : watch
      verdict_type want;
      verdict_type got;
      if (reset) begin
         recent_q.delete();
         verdict_q.delete();
         expiry_ticks = EXPIRY_RESET;
         cache_limit = LIMIT_RESET;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CSR_EXPIRY_TICKS) begin
               expiry_ticks = csr_bus.wdata;
            end else if (csr_bus.index == CSR_CACHE_LIMIT) begin
               cache_limit = csr_bus.wdata[LIMIT_W-1:0];
            end
         end
         // Responses are handled before requests, so a response beat can
         // never be matched against the request accepted on the same edge.
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen++;
            got.is_duplicate = rsp_bus.is_duplicate;
            got.entry_count = rsp_bus.entry_count;
            if (verdict_q.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("response beat %0d with nothing expected: dup=%0b count=%0d",
                           seen, got.is_duplicate, got.entry_count);
               end
            end else begin
               want = verdict_q[0];
               verdict_q.delete(0);
               if (got.is_duplicate !== want.is_duplicate ||
                   got.entry_count !== want.entry_count) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("response beat %0d: expected dup=%0b count=%0d, %s",
                              seen, want.is_duplicate, want.entry_count,
                              $sformatf("got dup=%0b count=%0d",
                                        got.is_duplicate, got.entry_count));
                  end
               end
               if (want.is_duplicate) repeats++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            lookup_request(req_bus.requester_addr, req_bus.request_id, req_bus.time_now, want);
            verdict_q = {verdict_q, want};
            if (recent_q.size() > peak) peak = recent_q.size();
         end
      end
      fail_count <= fails;
      outstanding <= verdict_q.size();
      responses_seen <= seen;
      repeats_seen <= repeats;
      peak_entries <= peak;
   end

endmodule

### test/tb.sv
// ============================================================================
// Duplicate filter testbench
// Drives directed corner cases and then phases of random request traffic
// under several expiry and limit settings, with random stalls on both
// channels, and reports the verdict of the checker.
// ============================================================================
module tb import rrdf_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   bit                steady   = 1'b0;
   logic [TICK_W-1:0] tick_now = '0;
   logic [REQ_W-1:0]  pool_addr [256];
   logic [ID_W-1:0]   pool_id [256];
   int                sent     = 0;
   int                settings = 0;
   int                fail_count;
   int                outstanding;
   int                responses_seen;
   int                repeats_seen;
   int                peak_entries;

   rrdf_req_if req_if ();
   rrdf_rsp_if rsp_if ();
   rrdf_csr_if csr_if ();

   recent_request_duplicate_filter_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   duplicate_filter_checker filter_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_if),
      .rsp_bus        (rsp_if),
      .csr_bus        (csr_if),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .responses_seen (responses_seen),
      .repeats_seen   (repeats_seen),
      .peak_entries   (peak_entries)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= 9);
   end

   initial begin
      #20_000_000;
      $display("Run stopped by the watchdog after %0d request beats.", sent);
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [REQ_W-1:0] random_addr();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      return wide[REQ_W-1:0];
   endfunction

   // The valid stays high from one beat to the next unless a gap is drawn.
   task automatic send_request(input logic [REQ_W-1:0] who, input logic [ID_W-1:0] id,
                               input logic [TICK_W-1:0] now);
      while (!steady && $urandom_range(0, 99) < 9) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.requester_addr <= who;
      req_if.request_id <= id;
      req_if.time_now <= now;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      @(posedge clock);
      settings++;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] expiry,
                            input logic [CSR_DATA_W-1:0] limit_word);
      drain();
      write_register(CSR_EXPIRY_TICKS, expiry);
      write_register(CSR_CACHE_LIMIT, limit_word);
   endtask

   // Neighboring pool slots often share a requester or an id, so near
   // misses on one key field come up as often as true repeats.
   task automatic fill_pool(input int size);
      int k;
      int r;
      for (k = 0; k < size; k++) begin
         r = $urandom_range(0, 3);
         if (k > 0 && r == 0) begin
            pool_addr[k] = pool_addr[k-1];
            pool_id[k] = $urandom();
         end else if (k > 0 && r == 1) begin
            pool_addr[k] = random_addr();
            pool_id[k] = pool_id[k-1];
         end else begin
            pool_addr[k] = random_addr();
            pool_id[k] = $urandom();
         end
      end
   endtask

   task automatic run_phase(input int items, input int pool_size, input int step_max,
                            input int noise_pct);
      int pick;
      int r;
      fill_pool(pool_size);
      repeat (items) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            tick_now = $urandom();
         end else if (r < 6) begin
            tick_now = tick_now - $urandom_range(1, step_max + 1);
         end else begin
            tick_now = tick_now + $urandom_range(0, step_max);
         end
         if ($urandom_range(0, 99) < noise_pct) begin
            send_request(random_addr(), $urandom(), tick_now);
         end else begin
            pick = $urandom_range(0, pool_size - 1);
            send_request(pool_addr[pick], pool_id[pick], tick_now);
         end
      end
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.requester_addr <= '0;
      req_if.request_id <= '0;
      req_if.time_now <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_EXPIRY_TICKS;
      csr_if.wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Settings after reset: expiry 10, limit 100.
      send_request('0, '0, 32'd0);
      send_request('0, '0, 32'd0);
      send_request('1, '1, 32'd5);
      send_request(48'd1, '0, 32'd5);
      // An age equal to the expiry still counts as live.
      send_request('0, '0, 32'd10);
      send_request(48'h8000_0000_0000, 32'h8000_0000, 32'd16);
      send_request('1, '1, 32'd16);
      send_request(48'h5555_5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE);
      send_request(48'h5555_5555_5555, 32'hAAAA_AAAA, 32'd3);
      // Time steps back, so the cached entry seems to lie in the future.
      send_request(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 32'd0);

      configure(32'd0, 32'd1);
      send_request(48'h1234, 32'd7, 32'd100);
      send_request(48'h1234, 32'd7, 32'd100);
      send_request(48'h1234, 32'd7, 32'd101);
      send_request(48'h4321, 32'd7, 32'd101);

      configure(32'd0, 32'd0);
      send_request(48'h4321, 32'd8, 32'd101);
      send_request(48'h4321, 32'd9, 32'd200);
      send_request(48'h4321, 32'd10, 32'd200);

      configure(32'hFFFF_FFFF, 32'd255);
      send_request(48'hFFFF_0000_FFFF, 32'h0000_FFFF, 32'd0);
      send_request(48'h0000_FFFF_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
      send_request(48'hFFFF_0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);

      configure(32'd40, 32'd16);
      tick_now = $urandom();
      run_phase(220, 24, 8, 15);

      // A long stretch with no stalls, filling the list to its full depth.
      configure(32'hFFFF_FFFF, {24'($urandom_range(0, 32'h00FF_FFFF)), 8'd255});
      steady = 1'b1;
      run_phase(300, 200, 1000, 20);
      steady = 1'b0;

      // The limit drops far below the count; each miss trims only one entry.
      drain();
      write_register(CSR_CACHE_LIMIT, 32'd5);
      run_phase(120, 200, 5, 30);

      configure(32'd0, 32'd1);
      run_phase(100, 4, 1, 10);

      configure(32'd3, 32'd128);
      tick_now = 32'hFFFF_FF00;
      run_phase(200, 12, 2, 10);

      configure($urandom(), $urandom_range(1, 128));
      run_phase(200, 64, 50000, 15);

      configure(32'd20, 32'd0);
      run_phase(100, 6, 6, 10);

      configure(32'd1000, 32'd64);
      run_phase(200, 96, 40, 15);

      configure(32'd7, 32'd2);
      run_phase(110, 5, 3, 10);

      drain();
      repeat (DEPTH + 16) @(posedge clock);
      $display("Covered %0d request beats and %0d register writes; %0d responses checked.",
               sent, settings, responses_seen);
      $display("Repeats flagged: %0d; fullest list: %0d entries; mismatches: %0d.",
               repeats_seen, peak_entries, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
